/* src/dpw_pkg.sv */
// shared widths, register indexes and reset values for the depth pixel to world point block
package dpw_pkg;

   // field widths
   localparam int COORD_BITS = 12;
   localparam int DEPTH_BITS = 16;
   localparam int SCALE_BITS = 24;
   localparam int PP_BITS    = 16;
   localparam int INV_BITS   = 24;
   localparam int QUAT_BITS  = 16;
   localparam int WORLD_BITS = 32;

   // configuration port
   localparam int CFG_ADDR_BITS = 6;
   localparam int CFG_DATA_BITS = 64;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_DEPTH_SCALE     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_PRINCIPAL_POINT = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_INVERSE_FOCAL   = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_POSE_QUATERNION = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_TRANSLATION_X   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_TRANSLATION_Y   = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_TRANSLATION_Z   = 3'd6;

   localparam logic [SCALE_BITS-1:0]  DEPTH_SCALE_RESET = 24'h01_0000;
   localparam logic [4*QUAT_BITS-1:0] QUATERNION_RESET  = 64'h4000_0000_0000_0000;

   // datapath widths
   localparam int DPROD_W   = DEPTH_BITS + SCALE_BITS;
   localparam int DEPTH_W   = WORLD_BITS - 1;
   localparam int DIFF_W    = (((COORD_BITS + 4) > PP_BITS) ? (COORD_BITS + 4) : PP_BITS) + 1;
   localparam int MAG_W     = DIFF_W - 1;
   localparam int IPROD_W   = DEPTH_W + INV_BITS;
   localparam int STEP_W    = IPROD_W + 1 - 16;
   localparam int SPLIT_W   = STEP_W / 2;
   localparam int LOPROD_W  = MAG_W + SPLIT_W;
   localparam int HIPROD_W  = MAG_W + STEP_W - SPLIT_W;
   localparam int MSUM_W    = MAG_W + STEP_W + 1;
   localparam int CAMR_W    = MSUM_W - 12;
   localparam int QPROD_W   = 2 * QUAT_BITS;
   localparam int RFULL_W   = QPROD_W + 3;
   localparam int ROT_W     = RFULL_W - 14;
   localparam int TPROD_W   = ROT_W + WORLD_BITS;
   localparam int ACC_W     = TPROD_W + 2;
   localparam int WSUM_W    = ACC_W - 14 + 1;

   // number of register stages from the input handshake to the result register
   localparam int PIPE_DEPTH = 10;

endpackage

/* src/depth_pixel_to_world_point.sv */
// top level: pixel plus raw depth to world point, ten stage pipeline with csr block
//
//   channel  direction  handshake                        payload
//   req      in         req_valid / req_ready            req_pixel_x, req_pixel_y, req_raw_depth
//   rsp      out        rsp_valid / rsp_ready            rsp_world_x, rsp_world_y, rsp_world_z
//   csr      in/out     csr_psel, csr_penable, csr_pready csr_paddr, csr_pwrite, csr_pwdata, csr_prdata
//
// one item per cycle sustained while rsp_ready is high; the accepting edge loads stage one and the item
// then passes each stage in turn to the result register, stage ten, from which it can be taken
// the stages follow the multiplier chain: depth scale, clamp, depth times 1/f, round, split product,
// join, sign and clamp, rotation products, row sum, translation add, each with its own stage
// each stage holds its item only while it and every stage ahead are full and rsp_ready is low, so a stall
// only backs up until a bubble is met; req_ready stays high while any stage ahead has room
// synchronous reset clears the valid bits and loads the configuration registers with their reset values
// the rotation matrix is rebuilt from the quaternion register every cycle via product and entry registers
module depth_pixel_to_world_point (
   input  logic                                  clock,
   input  logic                                  reset,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [dpw_pkg::COORD_BITS-1:0]        req_pixel_x,
   input  logic [dpw_pkg::COORD_BITS-1:0]        req_pixel_y,
   input  logic [dpw_pkg::DEPTH_BITS-1:0]        req_raw_depth,
   // result items
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [dpw_pkg::WORLD_BITS-1:0] rsp_world_x,
   output logic signed [dpw_pkg::WORLD_BITS-1:0] rsp_world_y,
   output logic signed [dpw_pkg::WORLD_BITS-1:0] rsp_world_z,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [dpw_pkg::CFG_ADDR_BITS-1:0]     csr_paddr,
   input  logic [dpw_pkg::CFG_DATA_BITS-1:0]     csr_pwdata,
   output logic [dpw_pkg::CFG_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   localparam int DEPTH_W  = dpw_pkg::DEPTH_W;
   localparam int DPROD_W  = dpw_pkg::DPROD_W;
   localparam int DIFF_W   = dpw_pkg::DIFF_W;
   localparam int MAG_W    = dpw_pkg::MAG_W;
   localparam int IPROD_W  = dpw_pkg::IPROD_W;
   localparam int STEP_W   = dpw_pkg::STEP_W;
   localparam int SPLIT_W  = dpw_pkg::SPLIT_W;
   localparam int LOPROD_W = dpw_pkg::LOPROD_W;
   localparam int HIPROD_W = dpw_pkg::HIPROD_W;
   localparam int MSUM_W   = dpw_pkg::MSUM_W;
   localparam int CAMR_W   = dpw_pkg::CAMR_W;
   localparam int QPROD_W  = dpw_pkg::QPROD_W;
   localparam int RFULL_W  = dpw_pkg::RFULL_W;
   localparam int ROT_W    = dpw_pkg::ROT_W;
   localparam int TPROD_W  = dpw_pkg::TPROD_W;
   localparam int ACC_W    = dpw_pkg::ACC_W;
   localparam int WSUM_W   = dpw_pkg::WSUM_W;
   localparam int WB       = dpw_pkg::WORLD_BITS;
   localparam int NST      = dpw_pkg::PIPE_DEPTH;

   localparam logic signed [RFULL_W-1:0] ROT_ONE = RFULL_W'(64'sd268435456);
   localparam logic [WB-1:0] SAT_MAX = {1'b0, {(WB-1){1'b1}}};
   localparam logic [WB-1:0] SAT_MIN = {1'b1, {(WB-1){1'b0}}};

   // ---------------------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------------------
   logic [dpw_pkg::SCALE_BITS-1:0]  depth_scale_ff;
   logic [2*dpw_pkg::PP_BITS-1:0]   principal_ff;
   logic [2*dpw_pkg::INV_BITS-1:0]  inv_focal_ff;
   logic [4*dpw_pkg::QUAT_BITS-1:0] quat_ff;
   logic [WB-1:0]                   trans_ff [3];

   logic                              csr_write;
   logic [dpw_pkg::REG_IDX_BITS-1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // registers sit on 8 byte boundaries
   assign csr_idx    = csr_paddr[dpw_pkg::CFG_ADDR_BITS-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_scale_ff <= dpw_pkg::DEPTH_SCALE_RESET;
         principal_ff   <= '0;
         inv_focal_ff   <= '0;
         quat_ff        <= dpw_pkg::QUATERNION_RESET;
         trans_ff[0]    <= '0;
         trans_ff[1]    <= '0;
         trans_ff[2]    <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            dpw_pkg::REG_DEPTH_SCALE:     depth_scale_ff <= csr_pwdata[dpw_pkg::SCALE_BITS-1:0];
            dpw_pkg::REG_PRINCIPAL_POINT: principal_ff   <= csr_pwdata[2*dpw_pkg::PP_BITS-1:0];
            dpw_pkg::REG_INVERSE_FOCAL:   inv_focal_ff   <= csr_pwdata[2*dpw_pkg::INV_BITS-1:0];
            dpw_pkg::REG_POSE_QUATERNION: quat_ff        <= csr_pwdata[4*dpw_pkg::QUAT_BITS-1:0];
            dpw_pkg::REG_TRANSLATION_X:   trans_ff[0]    <= csr_pwdata[WB-1:0];
            dpw_pkg::REG_TRANSLATION_Y:   trans_ff[1]    <= csr_pwdata[WB-1:0];
            dpw_pkg::REG_TRANSLATION_Z:   trans_ff[2]    <= csr_pwdata[WB-1:0];
            default: ;
         endcase
      end
   end

   // read mux, unused index reads zero
   always_comb begin
      case (csr_idx)
         dpw_pkg::REG_DEPTH_SCALE:     csr_prdata = dpw_pkg::CFG_DATA_BITS'(depth_scale_ff);
         dpw_pkg::REG_PRINCIPAL_POINT: csr_prdata = dpw_pkg::CFG_DATA_BITS'(principal_ff);
         dpw_pkg::REG_INVERSE_FOCAL:   csr_prdata = dpw_pkg::CFG_DATA_BITS'(inv_focal_ff);
         dpw_pkg::REG_POSE_QUATERNION: csr_prdata = dpw_pkg::CFG_DATA_BITS'(quat_ff);
         dpw_pkg::REG_TRANSLATION_X:   csr_prdata = dpw_pkg::CFG_DATA_BITS'(trans_ff[0]);
         dpw_pkg::REG_TRANSLATION_Y:   csr_prdata = dpw_pkg::CFG_DATA_BITS'(trans_ff[1]);
         dpw_pkg::REG_TRANSLATION_Z:   csr_prdata = dpw_pkg::CFG_DATA_BITS'(trans_ff[2]);
         default:                      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------------
   // rotation matrix from the quaternion, free running
   // the registers are to be written only while the pipe is empty, which the block does not enforce;
   // an item then passes the depth and lateral stages before it meets this path, which settles in time
   // ---------------------------------------------------------------------------------
   logic signed [dpw_pkg::QUAT_BITS-1:0] qw, qx, qy, qz;
   logic signed [QPROD_W-1:0] qxx_in, qyy_in, qzz_in, qxy_in, qxz_in, qyz_in;
   logic signed [QPROD_W-1:0] qwx_in, qwy_in, qwz_in;
   logic signed [QPROD_W-1:0] qxx_ff, qyy_ff, qzz_ff, qxy_ff, qxz_ff, qyz_ff;
   logic signed [QPROD_W-1:0] qwx_ff, qwy_ff, qwz_ff;
   logic signed [RFULL_W-1:0] rfull [3][3];
   logic signed [ROT_W-1:0]   rot_in [3][3];
   logic signed [ROT_W-1:0]   rot_ff [3][3];

   assign qw = $signed(quat_ff[4*dpw_pkg::QUAT_BITS-1:3*dpw_pkg::QUAT_BITS]);
   assign qx = $signed(quat_ff[3*dpw_pkg::QUAT_BITS-1:2*dpw_pkg::QUAT_BITS]);
   assign qy = $signed(quat_ff[2*dpw_pkg::QUAT_BITS-1:dpw_pkg::QUAT_BITS]);
   assign qz = $signed(quat_ff[dpw_pkg::QUAT_BITS-1:0]);

   always_comb begin
      qxx_in = QPROD_W'(qx) * QPROD_W'(qx);
      qyy_in = QPROD_W'(qy) * QPROD_W'(qy);
      qzz_in = QPROD_W'(qz) * QPROD_W'(qz);
      qxy_in = QPROD_W'(qx) * QPROD_W'(qy);
      qxz_in = QPROD_W'(qx) * QPROD_W'(qz);
      qyz_in = QPROD_W'(qy) * QPROD_W'(qz);
      qwx_in = QPROD_W'(qw) * QPROD_W'(qx);
      qwy_in = QPROD_W'(qw) * QPROD_W'(qy);
      qwz_in = QPROD_W'(qw) * QPROD_W'(qz);
   end

   always_ff @(posedge clock) begin
      qxx_ff <= qxx_in;
      qyy_ff <= qyy_in;
      qzz_ff <= qzz_in;
      qxy_ff <= qxy_in;
      qxz_ff <= qxz_in;
      qyz_ff <= qyz_in;
      qwx_ff <= qwx_in;
      qwy_ff <= qwy_in;
      qwz_ff <= qwz_in;
   end

   // entries in Q.28, then rounded half up to Q.14
   always_comb begin
      rfull[0][0] = ROT_ONE - ((RFULL_W'(qyy_ff) + RFULL_W'(qzz_ff)) <<< 1);
      rfull[0][1] = (RFULL_W'(qxy_ff) - RFULL_W'(qwz_ff)) <<< 1;
      rfull[0][2] = (RFULL_W'(qxz_ff) + RFULL_W'(qwy_ff)) <<< 1;
      rfull[1][0] = (RFULL_W'(qxy_ff) + RFULL_W'(qwz_ff)) <<< 1;
      rfull[1][1] = ROT_ONE - ((RFULL_W'(qxx_ff) + RFULL_W'(qzz_ff)) <<< 1);
      rfull[1][2] = (RFULL_W'(qyz_ff) - RFULL_W'(qwx_ff)) <<< 1;
      rfull[2][0] = (RFULL_W'(qxz_ff) - RFULL_W'(qwy_ff)) <<< 1;
      rfull[2][1] = (RFULL_W'(qyz_ff) + RFULL_W'(qwx_ff)) <<< 1;
      rfull[2][2] = ROT_ONE - ((RFULL_W'(qxx_ff) + RFULL_W'(qyy_ff)) <<< 1);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rot_in[i][j] = ROT_W'((rfull[i][j] + RFULL_W'(64'sd8192)) >>> 14);
         end
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
   end

   // ---------------------------------------------------------------------------------
   // stage control: a stage loads when it is empty or everything ahead of it moves
   // ---------------------------------------------------------------------------------
   logic [NST-1:0] vld_ff, vld_in, adv;

   for (genvar k = 0; k < NST; k++) begin : g_adv
      assign adv[k] = rsp_ready | ~(&vld_ff[NST-1:k]);
   end

   always_comb begin
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NST; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[NST-1];

   // ---------------------------------------------------------------------------------
   // datapath, index 0 is the x axis and 1 the y axis for the lateral terms
   // ---------------------------------------------------------------------------------
   logic [dpw_pkg::INV_BITS-1:0] inv_sel [2];
   assign inv_sel[0] = inv_focal_ff[2*dpw_pkg::INV_BITS-1:dpw_pkg::INV_BITS];
   assign inv_sel[1] = inv_focal_ff[dpw_pkg::INV_BITS-1:0];

   // stage 1: raw depth times scale, pixel offset from the principal point in Q.4
   logic [DPROD_W-1:0] s1_dprod_in, s1_dprod_ff;
   logic [DIFF_W-1:0]  s1_diff_in [2];
   logic [DIFF_W-1:0]  s1_diff_ff [2];

   always_comb begin
      s1_dprod_in   = DPROD_W'(req_raw_depth) * DPROD_W'(depth_scale_ff);
      s1_diff_in[0] = DIFF_W'({req_pixel_x, 4'b0000})
                    - DIFF_W'(principal_ff[2*dpw_pkg::PP_BITS-1:dpw_pkg::PP_BITS]);
      s1_diff_in[1] = DIFF_W'({req_pixel_y, 4'b0000})
                    - DIFF_W'(principal_ff[dpw_pkg::PP_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_dprod_ff <= s1_dprod_in;
         s1_diff_ff  <= s1_diff_in;
      end
   end

   // stage 2: clamp depth to the positive Q16.16 range, split offsets into sign and size
   logic [DEPTH_W-1:0] s2_depth_in, s2_depth_ff;
   logic [MAG_W-1:0]   s2_mag_in [2];
   logic [MAG_W-1:0]   s2_mag_ff [2];
   logic [1:0]         s2_neg_in, s2_neg_ff;

   always_comb begin
      s2_depth_in = (|s1_dprod_ff[DPROD_W-1:DEPTH_W]) ? {DEPTH_W{1'b1}}
                                                       : s1_dprod_ff[DEPTH_W-1:0];
      for (int a = 0; a < 2; a++) begin
         s2_neg_in[a] = s1_diff_ff[a][DIFF_W-1];
         s2_mag_in[a] = s2_neg_in[a] ? MAG_W'(-s1_diff_ff[a]) : MAG_W'(s1_diff_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_depth_ff <= s2_depth_in;
         s2_mag_ff   <= s2_mag_in;
         s2_neg_ff   <= s2_neg_in;
      end
   end

   // stage 3: depth times reciprocal focal length
   logic [IPROD_W-1:0] s3_iprod_in [2];
   logic [IPROD_W-1:0] s3_iprod_ff [2];
   logic [DEPTH_W-1:0] s3_depth_ff;
   logic [MAG_W-1:0]   s3_mag_ff [2];
   logic [1:0]         s3_neg_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         s3_iprod_in[a] = IPROD_W'(s2_depth_ff) * IPROD_W'(inv_sel[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_iprod_ff <= s3_iprod_in;
         s3_depth_ff <= s2_depth_ff;
         s3_mag_ff   <= s2_mag_ff;
         s3_neg_ff   <= s2_neg_ff;
      end
   end

   // stage 4: round the step size to Q.24
   logic [IPROD_W:0]   s4_round [2];
   logic [STEP_W-1:0]  s4_step_in [2];
   logic [STEP_W-1:0]  s4_step_ff [2];
   logic [DEPTH_W-1:0] s4_depth_ff;
   logic [MAG_W-1:0]   s4_mag_ff [2];
   logic [1:0]         s4_neg_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         s4_round[a]   = (IPROD_W+1)'(s3_iprod_ff[a]) + (IPROD_W+1)'(32768);
         s4_step_in[a] = s4_round[a][IPROD_W:16];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_step_ff  <= s4_step_in;
         s4_depth_ff <= s3_depth_ff;
         s4_mag_ff   <= s3_mag_ff;
         s4_neg_ff   <= s3_neg_ff;
      end
   end

   // stage 5: offset size times step, as two half width partial products
   logic [LOPROD_W-1:0] s5_plo_in [2];
   logic [LOPROD_W-1:0] s5_plo_ff [2];
   logic [HIPROD_W-1:0] s5_phi_in [2];
   logic [HIPROD_W-1:0] s5_phi_ff [2];
   logic [DEPTH_W-1:0]  s5_depth_ff;
   logic [1:0]          s5_neg_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         s5_plo_in[a] = LOPROD_W'(s4_mag_ff[a]) * LOPROD_W'(s4_step_ff[a][SPLIT_W-1:0]);
         s5_phi_in[a] = HIPROD_W'(s4_mag_ff[a]) * HIPROD_W'(s4_step_ff[a][STEP_W-1:SPLIT_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_plo_ff   <= s5_plo_in;
         s5_phi_ff   <= s5_phi_in;
         s5_depth_ff <= s4_depth_ff;
         s5_neg_ff   <= s4_neg_ff;
      end
   end

   // stage 6: join the partial products and round Q.28 down to Q.16
   logic [MSUM_W-1:0]  s6_sum [2];
   logic [CAMR_W-1:0]  s6_camr_in [2];
   logic [CAMR_W-1:0]  s6_camr_ff [2];
   logic [DEPTH_W-1:0] s6_depth_ff;
   logic [1:0]         s6_neg_ff;

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         s6_sum[a]     = MSUM_W'({s5_phi_ff[a], SPLIT_W'(0)}) + MSUM_W'(s5_plo_ff[a])
                       + MSUM_W'(2048);
         s6_camr_in[a] = s6_sum[a][MSUM_W-1:12];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_camr_ff  <= s6_camr_in;
         s6_depth_ff <= s5_depth_ff;
         s6_neg_ff   <= s5_neg_ff;
      end
   end

   // stage 7: put the sign back and clamp to 32 bits, depth becomes camera z
   logic [WB-1:0] s7_cam_in [3];
   logic [WB-1:0] s7_cam_ff [3];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         if (!s6_neg_ff[a]) begin
            s7_cam_in[a] = (|s6_camr_ff[a][CAMR_W-1:WB-1]) ? SAT_MAX
                                                              : s6_camr_ff[a][WB-1:0];
         end else if ((|s6_camr_ff[a][CAMR_W-1:WB])
                      || (s6_camr_ff[a][WB-1] && (|s6_camr_ff[a][WB-2:0]))) begin
            s7_cam_in[a] = SAT_MIN;
         end else begin
            s7_cam_in[a] = -s6_camr_ff[a][WB-1:0];
         end
      end
      s7_cam_in[2] = {1'b0, s6_depth_ff};
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_cam_ff <= s7_cam_in;
      end
   end

   // stage 8: nine rotation products
   logic signed [TPROD_W-1:0] s8_tprod_in [3][3];
   logic signed [TPROD_W-1:0] s8_tprod_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s8_tprod_in[i][j] = TPROD_W'(rot_ff[i][j]) * TPROD_W'($signed(s7_cam_ff[j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s8_tprod_ff <= s8_tprod_in;
      end
   end

   // stage 9: row sums with the rounding bias
   logic signed [ACC_W-1:0] s9_acc_in [3];
   logic signed [ACC_W-1:0] s9_acc_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s9_acc_in[i] = ACC_W'(s8_tprod_ff[i][0]) + ACC_W'(s8_tprod_ff[i][1])
                      + ACC_W'(s8_tprod_ff[i][2]) + ACC_W'(64'sd8192);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s9_acc_ff <= s9_acc_in;
      end
   end

   // stage 10: drop to Q16.16, add translation, clamp; this is the result register
   logic signed [WSUM_W-1:0] s10_sum [3];
   logic [WB-1:0]            s10_world_in [3];
   logic [WB-1:0]            s10_world_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s10_sum[i] = WSUM_W'($signed(s9_acc_ff[i][ACC_W-1:14]))
                    + WSUM_W'($signed(trans_ff[i]));
         if (!s10_sum[i][WSUM_W-1] && (|s10_sum[i][WSUM_W-2:WB-1])) begin
            s10_world_in[i] = SAT_MAX;
         end else if (s10_sum[i][WSUM_W-1] && !(&s10_sum[i][WSUM_W-2:WB-1])) begin
            s10_world_in[i] = SAT_MIN;
         end else begin
            s10_world_in[i] = s10_sum[i][WB-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[9]) begin
         s10_world_ff <= s10_world_in;
      end
   end

   assign rsp_world_x = $signed(s10_world_ff[0]);
   assign rsp_world_y = $signed(s10_world_ff[1]);
   assign rsp_world_z = $signed(s10_world_ff[2]);

endmodule

/* src/dpw_checker.sv */
// port level checks for the depth pixel to world point block, bound to the top level
module dpw_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [dpw_pkg::WORLD_BITS-1:0] rsp_world_x,
   input logic signed [dpw_pkg::WORLD_BITS-1:0] rsp_world_y,
   input logic signed [dpw_pkg::WORLD_BITS-1:0] rsp_world_z
);

   localparam int CNT_W = $clog2(dpw_pkg::PIPE_DEPTH + 1) + 1;

   // items accepted and not yet delivered
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign cnt_in = cnt_ff + CNT_W'(req_valid & req_ready) - CNT_W'(rsp_valid & rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_world_x)
                                  && $stable(rsp_world_y) && $stable(rsp_world_z))
      else $error("result changed while stalled");

   // no result without an item behind it
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("result shown with no item in flight");

   // never more items inside than stages
   a_capacity: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(dpw_pkg::PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

   // a draining output must let the input flow
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output is taken");

endmodule

bind depth_pixel_to_world_point dpw_checker u_dpw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_world_x (rsp_world_x),
   .rsp_world_y (rsp_world_y),
   .rsp_world_z (rsp_world_z)
);
